// ----- hdl/rlfs_pkg.sv -----
// Shared constants, types and helpers for the RGB LED frame store.
package rlfs_pkg;

  localparam int NUM_LEDS = 20;
  localparam int LED_AW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  localparam logic [2:0] OP_BRIGHT = 3'd0;
  localparam logic [2:0] OP_COLOUR = 3'd1;
  localparam logic [2:0] OP_ON     = 3'd2;
  localparam logic [2:0] OP_OFF    = 3'd3;
  localparam logic [2:0] OP_FLUSH  = 3'd4;

  localparam logic [7:0] LED_HEADER = 8'hE0;
  localparam logic [4:0] LEVEL_MAX  = 5'd31;
  localparam logic [8:0] Q_FULL     = 9'd256;
  localparam logic [7:0] LED_COUNT  = 8'(NUM_LEDS);

  typedef logic [LED_AW-1:0] led_addr_t;

  typedef struct packed {
    logic [4:0] remembered;
    logic [4:0] shown;
    logic       on;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_entry_t;

  typedef struct packed {
    logic       rd_en;
    led_addr_t  rd_addr;
    logic       wr_en;
    led_addr_t  wr_addr;
    led_entry_t wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic        load;
    logic [31:0] word;
    logic        last;
  } emit_t;

  function automatic logic [4:0] q_to_level(input logic [8:0] q);
    logic [13:0] prod;
    prod = 14'(q) * 14'(LEVEL_MAX);
    return prod[12:8];
  endfunction

endpackage

// ----- hdl/rlfs_if.sv -----
// Valid/ready channel interfaces for the command input and the frame word output.
interface rlfs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] led_index;
  logic [8:0] brightness_q;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, op, led_index, brightness_q, red, green, blue, input ready);
  modport sink(input valid, op, led_index, brightness_q, red, green, blue, output ready);
endinterface

interface rlfs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_word;
  logic        last_word;

  modport source(output valid, frame_word, last_word, input ready);
  modport sink(input valid, frame_word, last_word, output ready);
endinterface

// ----- hdl/rlfs_table.sv -----
// LED table memory with registered read and per-entry valid bits.
module rlfs_table import rlfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tbl_req_t   req,
  output led_entry_t rd_data
);

  led_entry_t            mem_r [NUM_LEDS];
  logic [NUM_LEDS-1:0]   valid_r;
  led_entry_t            rd_word_r;
  logic                  rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit_r <= valid_r[req.rd_addr];
      end
    end
  end

  // never-written entries read as the reset value
  assign rd_data = rd_hit_r ? rd_word_r : '0;

endmodule

// ----- hdl/rlfs_ctrl.sv -----
// Command sequencer: read-modify-write of table entries and frame flush.
module rlfs_ctrl import rlfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rlfs_in_if.sink    in_ch,
  input  led_entry_t rd_data,
  input  logic       out_free,
  output tbl_req_t   req,
  output emit_t      emit
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [2:0] state_r, state_nxt;
  led_addr_t  cnt_r, cnt_nxt;
  logic [2:0] op_r;
  led_addr_t  addr_r;
  logic [4:0] lvl_r;
  logic [7:0] red_r, green_r, blue_r;

  logic       accept;
  logic       in_range;
  logic       op_effective;
  led_entry_t entry;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_range     = (in_ch.led_index < LED_COUNT);
  assign op_effective = (in_ch.op inside {OP_COLOUR, OP_ON, OP_OFF}) ||
                        ((in_ch.op == OP_BRIGHT) && (in_ch.brightness_q <= Q_FULL));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    req       = '0;
    emit      = '0;
    entry     = rd_data;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.op == OP_FLUSH) begin
            req.rd_en   = 1'b1;
            req.rd_addr = '0;
            cnt_nxt     = '0;
            state_nxt   = S_START;
          end else if (in_range && op_effective) begin
            req.rd_en   = 1'b1;
            req.rd_addr = led_addr_t'(in_ch.led_index);
            state_nxt   = S_MOD;
          end
        end
      end
      S_MOD: begin
        case (op_r)
          OP_BRIGHT: begin
            entry.remembered = lvl_r;
            if (entry.on) begin
              entry.shown = lvl_r;
            end
          end
          OP_COLOUR: begin
            entry.red   = red_r;
            entry.green = green_r;
            entry.blue  = blue_r;
          end
          OP_ON: begin
            entry.on    = 1'b1;
            entry.shown = entry.remembered;
          end
          OP_OFF: begin
            entry.on    = 1'b0;
            entry.shown = '0;
          end
          default: ;
        endcase
        req.wr_en   = 1'b1;
        req.wr_addr = addr_r;
        req.wr_data = entry;
        state_nxt   = S_IDLE;
      end
      S_START: begin
        if (out_free) begin
          emit.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (out_free) begin
          emit.load = 1'b1;
          emit.word = {LED_HEADER | {3'b000, rd_data.shown},
                       rd_data.blue, rd_data.green, rd_data.red};
          if (cnt_r == led_addr_t'(NUM_LEDS - 1)) begin
            state_nxt = S_END;
          end else begin
            cnt_nxt     = led_addr_t'(cnt_r + 1'b1);
            req.rd_en   = 1'b1;
            req.rd_addr = led_addr_t'(cnt_r + 1'b1);
          end
        end
      end
      S_END: begin
        if (out_free) begin
          emit.load = 1'b1;
          emit.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // capture the command payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.op;
      addr_r  <= led_addr_t'(in_ch.led_index);
      lvl_r   <= q_to_level(in_ch.brightness_q);
      red_r   <= in_ch.red;
      green_r <= in_ch.green;
      blue_r  <= in_ch.blue;
    end
  end

endmodule

// ----- hdl/rgb_led_frame_store_unit.sv -----
// Set ops: a set command is accepted, then written back in the following cycle; ready returns after.
// Input: ready drops while a set op is written back; dropped ops leave ready high.
// Flush: NUM_LEDS + 2 words, one per cycle while the sink takes them; the start word is
// loaded into the output register from S_START, and input is held off until the end word is loaded.
// Reset: rst_n clears control and the table valid bits, so every LED reads as all zero.
module rgb_led_frame_store_unit import rlfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rlfs_in_if.sink     in_ch,
  rlfs_out_if.source  out_ch
);

  tbl_req_t    req;
  led_entry_t  rd_data;
  emit_t       emit;
  logic        out_free;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic        out_last_r;

  rlfs_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  rlfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .rd_data  (rd_data),
    .out_free (out_free),
    .req      (req),
    .emit     (emit)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_word_r <= emit.word;
      out_last_r <= emit.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_word = out_word_r;
  assign out_ch.last_word  = out_last_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> out_free)
    else $error("frame word loaded over an untaken word");

  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_word |-> out_ch.frame_word == 32'd0)
    else $error("end word is not zero");

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.op == OP_FLUSH |=> !in_ch.ready)
    else $error("input taken during flush");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> !req.rd_en && !emit.load)
    else $error("table write overlaps a read or emit");
`endif

endmodule

// ----- tb/sv/rgb_led_frame_store_unit_checker.sv -----
// Frame store checker: mirrors the LED table and compares every frame word that leaves the block.
`timescale 1ns / 100ps
module rgb_led_frame_store_unit_checker import rlfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rlfs_in_if   in_mon,
  rlfs_out_if  out_mon,
  output int   fail_count,
  output int   words_pending,
  output int   words_checked
);

  typedef struct packed {
    logic [31:0] frame_word;
    logic        last_word;
  } frame_beat_t;

  logic [4:0]  led_remembered [NUM_LEDS];
  logic [4:0]  led_shown      [NUM_LEDS];
  logic        led_lit        [NUM_LEDS];
  logic [23:0] led_rgb        [NUM_LEDS];
  frame_beat_t frame_queue[$];
  frame_beat_t want;
  logic [4:0]  new_level;
  int          idx;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_remembered[i] = '0;
        led_shown[i]      = '0;
        led_lit[i]        = 1'b0;
        led_rgb[i]        = '0;
      end
      frame_queue.delete();
      fail_count    = 0;
      words_checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (frame_queue.size() == 0) begin
          $display("%0t: unexpected frame word: expected none, actual %h last %b",
                   $time, out_mon.frame_word, out_mon.last_word);
          fail_count++;
        end else begin
          want = frame_queue.pop_front();
          words_checked++;
          if (out_mon.frame_word !== want.frame_word ||
              out_mon.last_word !== want.last_word) begin
            $display("%0t: frame word mismatch: expected %h last %b, actual %h last %b",
                     $time, want.frame_word, want.last_word,
                     out_mon.frame_word, out_mon.last_word);
            fail_count++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        idx = int'(in_mon.led_index);
        if (in_mon.op == OP_FLUSH) begin
          frame_queue.push_back('{32'd0, 1'b0});
          for (int i = 0; i < NUM_LEDS; i++)
            frame_queue.push_back('{{LED_HEADER | {3'd0, led_shown[i]},
                                     led_rgb[i][7:0], led_rgb[i][15:8], led_rgb[i][23:16]},
                                    1'b0});
          frame_queue.push_back('{32'd0, 1'b1});
        end else if (idx < NUM_LEDS) begin
          case (in_mon.op)
            OP_BRIGHT: begin
              if (in_mon.brightness_q <= Q_FULL) begin
                new_level = 5'((int'(in_mon.brightness_q) * int'(LEVEL_MAX)) >> 8);
                led_remembered[idx] = new_level;
                if (led_lit[idx])
                  led_shown[idx] = new_level;
              end
            end
            OP_COLOUR: led_rgb[idx] = {in_mon.red, in_mon.green, in_mon.blue};
            OP_ON: begin
              led_lit[idx]   = 1'b1;
              led_shown[idx] = led_remembered[idx];
            end
            OP_OFF: begin
              led_lit[idx]   = 1'b0;
              led_shown[idx] = '0;
            end
            default: ;
          endcase
        end
      end
    end
    words_pending = frame_queue.size();
  end

endmodule

// ----- tb/sv/rgb_led_frame_store_unit_tb.sv -----
// Frame store testbench top: drives LED commands and output backpressure, then gives the verdict.
`timescale 1ns / 100ps
module rgb_led_frame_store_unit_tb;
  import rlfs_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         RANDOM_CMDS = 350;
  localparam int         DRAIN_LIMIT = 20000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   fail_count, words_pending, words_checked;
  int   cmds_sent, flushes_sent, tail_errors;

  rlfs_in_if  in_ch();
  rlfs_out_if out_ch();

  rgb_led_frame_store_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rgb_led_frame_store_unit_checker frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);

  initial begin
    #20_000_000;
    $display("%0t: timeout, %0d frame words still pending", $time, words_pending);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_cmd(input logic [2:0] op, input logic [7:0] idx, input logic [8:0] q,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.led_index    <= idx;
    in_ch.brightness_q <= q;
    in_ch.red          <= r;
    in_ch.green        <= g;
    in_ch.blue         <= b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    cmds_sent++;
    if (op == OP_FLUSH)
      flushes_sent++;
  endtask

  initial begin
    logic [2:0] op;
    logic [7:0] idx;
    logic [8:0] q;
    int         sel, counted, timer;
    logic [7:0] last_led;

    last_led           = LED_COUNT - 8'd1;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_BRIGHT;
    in_ch.led_index    = '0;
    in_ch.brightness_q = '0;
    in_ch.red          = '0;
    in_ch.green        = '0;
    in_ch.blue         = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_cmd(OP_FLUSH,  8'd0, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_COLOUR, 8'd0, 9'd0, 8'hFF, 8'h00, 8'h55);
    send_cmd(OP_COLOUR, last_led, 9'd0, 8'h00, 8'hFF, 8'hAA);
    send_cmd(OP_COLOUR, 8'd1, 9'd0, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_BRIGHT, 8'd0, Q_FULL, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_FLUSH,  8'd0, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_ON,     8'd0, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_BRIGHT, 8'd0, Q_FULL + 9'd1, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_BRIGHT, 8'd0, 9'h1FF, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_BRIGHT, last_led, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_ON,     last_led, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_BRIGHT, last_led, Q_FULL - 9'd1, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_BRIGHT, 8'd1, 9'd128, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_ON,     8'd1, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_OFF,    8'd1, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_BRIGHT, 8'd1, 9'd1, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_COLOUR, LED_COUNT, 9'd0, 8'h12, 8'h34, 8'h56);
    send_cmd(OP_BRIGHT, 8'hFF, Q_FULL, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_ON,     LED_COUNT, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_SPARE_LO, 8'd0, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_SPARE_LO + 3'd1, 8'd0, Q_FULL, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_SPARE_HI, 8'd0, 9'h1FF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_FLUSH,  8'd0, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_ON,     8'd1, 9'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_FLUSH,  8'd0, 9'd0, 8'h00, 8'h00, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 83; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      counted = 0;
      while (counted < RANDOM_CMDS / 4) begin
        sel = $urandom_range(99);
        if (sel < 25)      op = OP_BRIGHT;
        else if (sel < 48) op = OP_COLOUR;
        else if (sel < 63) op = OP_ON;
        else if (sel < 78) op = OP_OFF;
        else if (sel < 90) op = OP_FLUSH;
        else               op = 3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
        if ($urandom_range(99) < 88) idx = 8'($urandom_range(NUM_LEDS - 1));
        else                         idx = 8'($urandom_range(255, NUM_LEDS));
        if ($urandom_range(99) < 85) q = 9'($urandom_range(int'(Q_FULL)));
        else                         q = 9'($urandom_range(511, int'(Q_FULL) + 1));
        send_cmd(op, idx, q, 8'($urandom), 8'($urandom), 8'($urandom));
        counted++;
      end
    end
    in_ch.valid <= 1'b0;

    timer = 0;
    while (words_pending != 0 && timer < DRAIN_LIMIT) begin
      @(negedge clk);
      timer++;
    end
    if (words_pending != 0) begin
      $display("%0t: %0d expected frame words never arrived", $time, words_pending);
      tail_errors++;
    end
    repeat (40) @(negedge clk);

    $display("Sent %0d commands including %0d flushes over four idle/backpressure mixes.",
             cmds_sent, flushes_sent);
    $display("Checked %0d frame words against the mirrored LED table.", words_checked);
    if (fail_count == 0 && tail_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rlfs_pkg.sv
hdl/rlfs_if.sv
hdl/rlfs_table.sv
hdl/rlfs_ctrl.sv
hdl/rgb_led_frame_store_unit.sv
tb/sv/rgb_led_frame_store_unit_checker.sv
tb/sv/rgb_led_frame_store_unit_tb.sv
